// ----- design/lcg_pkg.sv -----
// Shared types, constants and helper functions for the life cell generation stream.
// Used by every module of the block; depends on nothing else.
package lcg_pkg;

  // Grid geometry limits
  localparam int MAX_COLS     = 32;
  localparam int MAX_ROWS     = 1024;
  localparam int WINDOW_CELLS = 9;
  localparam int COL_W        = $clog2(MAX_COLS);
  localparam int ROW_W        = $clog2(MAX_ROWS);

  // Configuration register widths
  localparam int ROWS_CFG_W = 11;
  localparam int COLS_CFG_W = 6;
  localparam int RULE_W     = 4;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 3;

  // Job queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Register reset values
  localparam logic [ROWS_CFG_W-1:0] ROWS_RESET  = ROWS_CFG_W'(1024);
  localparam logic [COLS_CFG_W-1:0] COLS_RESET  = COLS_CFG_W'(32);
  localparam logic [RULE_W-1:0]     BIRTH_RESET = RULE_W'(3);
  localparam logic [RULE_W-1:0]     SMIN_RESET  = RULE_W'(2);
  localparam logic [RULE_W-1:0]     SMAX_RESET  = RULE_W'(3);

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROWS  = 3'd0,
    CFG_COLS  = 3'd1,
    CFG_BIRTH = 3'd2,
    CFG_SMIN  = 3'd3,
    CFG_SMAX  = 3'd4
  } cfg_reg_t;

  typedef logic [MAX_COLS-1:0]     line_t;
  typedef logic [WINDOW_CELLS-1:0] win_t;

  // Effective geometry, stored as last index
  typedef struct packed {
    logic [COL_W-1:0] ncols_m1;
    logic [ROW_W-1:0] nrows_m1;
  } geom_t;

  // Life rule
  typedef struct packed {
    logic [RULE_W-1:0] birth;
    logic [RULE_W-1:0] smin;
    logic [RULE_W-1:0] smax;
  } rule_t;

  // One job: up to two row results plus an optional end-of-frame flush
  typedef struct packed {
    logic             emit_a;   // result at column col-1 of row row-1
    logic             emit_b;   // result at column col of row row-1
    logic             flush;    // whole row row, lower neighbors dead
    win_t             win_a;
    win_t             win_b;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    line_t            fl_up;
    line_t            fl_mid;
  } job_t;

  // Clamp rows_in_use to 1..MAX_ROWS, return last row index
  function automatic logic [ROW_W-1:0] last_row_idx(input logic [ROWS_CFG_W-1:0] rows);
    logic [ROWS_CFG_W-1:0] m1;
    m1 = rows - ROWS_CFG_W'(1);
    if (rows == '0) begin
      return '0;
    end else if (rows > ROWS_CFG_W'(MAX_ROWS)) begin
      return ROW_W'(MAX_ROWS - 1);
    end
    return m1[ROW_W-1:0];
  endfunction

  // Clamp cols_in_use to 1..MAX_COLS, return last column index
  function automatic logic [COL_W-1:0] last_col_idx(input logic [COLS_CFG_W-1:0] cols);
    logic [COLS_CFG_W-1:0] m1;
    m1 = cols - COLS_CFG_W'(1);
    if (cols == '0) begin
      return '0;
    end else if (cols > COLS_CFG_W'(MAX_COLS)) begin
      return COL_W'(MAX_COLS - 1);
    end
    return m1[COL_W-1:0];
  endfunction

  // 3x3 window around column x; bits [2:0] upper row, [5:3] middle, [8:6] lower.
  // Cells beyond the grid read as dead through the zero padding.
  function automatic win_t window3(input line_t up, input line_t mid, input line_t dn,
                                   input logic [COL_W-1:0] x);
    logic [MAX_COLS+1:0] pu;
    logic [MAX_COLS+1:0] pm;
    logic [MAX_COLS+1:0] pd;
    pu = {1'b0, up, 1'b0};
    pm = {1'b0, mid, 1'b0};
    pd = {1'b0, dn, 1'b0};
    return {pd[x +: 3], pm[x +: 3], pu[x +: 3]};
  endfunction

  // Apply the birth/survival rule to one window
  function automatic logic next_state(input win_t w, input rule_t r);
    logic [RULE_W-1:0] n;
    n = '0;
    for (int i = 0; i < WINDOW_CELLS; i++) begin
      if (i != WINDOW_CELLS / 2) begin
        n = n + RULE_W'(w[i]);
      end
    end
    if (w[WINDOW_CELLS / 2]) begin
      return (n >= r.smin) && (n <= r.smax);
    end
    return n == r.birth;
  endfunction

endpackage

// ----- design/lcg_front.sv -----
// Front end: accepts cells, keeps the three line buffers and raster position,
// and turns each request into a job for the back end. Depends on lcg_pkg.
module lcg_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                restart,
  input  logic                accept,
  input  logic                cell_alive,
  input  lcg_pkg::geom_t      geom,
  output logic                job_push,
  output lcg_pkg::job_t       job
);

  lcg_pkg::line_t                line_above;
  lcg_pkg::line_t                line_middle;
  lcg_pkg::line_t                line_incoming;
  logic [lcg_pkg::ROW_W-1:0]     row_position;
  logic [lcg_pkg::COL_W-1:0]     col_position;

  lcg_pkg::line_t                incoming_upd;
  logic                          last_col;
  logic                          last_row;
  logic [lcg_pkg::COL_W-1:0]     col_prev;

  // Merge the new cell into the row being filled
  always_comb begin
    incoming_upd               = line_incoming;
    incoming_upd[col_position] = line_incoming[col_position] | cell_alive;
    last_col                   = (col_position == geom.ncols_m1);
    last_row                   = (row_position == geom.nrows_m1);
    col_prev                   = col_position - lcg_pkg::COL_W'(1);
  end

  // Classify the request into a job
  always_comb begin
    job.emit_a = (row_position != '0) && (col_position != '0);
    job.emit_b = (row_position != '0) && last_col;
    job.flush  = last_col && last_row;
    job.win_a  = lcg_pkg::window3(line_above, line_middle, incoming_upd, col_prev);
    job.win_b  = lcg_pkg::window3(line_above, line_middle, incoming_upd, col_position);
    job.row    = row_position;
    job.col    = col_position;
    job.fl_up  = line_middle;
    job.fl_mid = incoming_upd;
    job_push   = accept && (job.emit_a || job.emit_b || job.flush);
  end

  // Line buffers and raster position
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      line_above    <= '0;
      line_middle   <= '0;
      line_incoming <= '0;
      row_position  <= '0;
      col_position  <= '0;
    end else if (accept) begin
      if (last_col && last_row) begin
        line_above    <= '0;
        line_middle   <= '0;
        line_incoming <= '0;
        row_position  <= '0;
        col_position  <= '0;
      end else if (last_col) begin
        line_above    <= line_middle;
        line_middle   <= incoming_upd;
        line_incoming <= '0;
        row_position  <= row_position + lcg_pkg::ROW_W'(1);
        col_position  <= '0;
      end else begin
        line_incoming <= incoming_upd;
        col_position  <= col_position + lcg_pkg::COL_W'(1);
      end
    end
  end

  // Position stays inside the configured grid
  a_pos_in_grid: assert property (@(posedge clk) disable iff (rst)
    (col_position <= geom.ncols_m1) && (row_position <= geom.nrows_m1))
    else $error("raster position outside grid");

endmodule

// ----- design/lcg_queue.sv -----
// Short job queue that decouples the front end from the back end.
// Register-based, depth from lcg_pkg::Q_DEPTH. Depends on lcg_pkg.
module lcg_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  lcg_pkg::job_t wr_data,
  input  logic          rd,
  output lcg_pkg::job_t rd_data,
  output logic          empty,
  output logic          full
);

  lcg_pkg::job_t                 slots [lcg_pkg::Q_DEPTH];
  logic [lcg_pkg::Q_PTR_W-1:0]   wr_ptr;
  logic [lcg_pkg::Q_PTR_W-1:0]   rd_ptr;
  logic [lcg_pkg::Q_CNT_W-1:0]   count;
  logic                          do_wr;
  logic                          do_rd;

  assign empty   = (count == '0);
  assign full    = (count == lcg_pkg::Q_CNT_W'(lcg_pkg::Q_DEPTH));
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !empty;
  assign rd_data = slots[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + lcg_pkg::Q_PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + lcg_pkg::Q_PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + lcg_pkg::Q_CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - lcg_pkg::Q_CNT_W'(1);
      end
    end
  end

  // No job is dropped or read from an empty queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(wr && full) && !(rd && empty))
    else $error("job queue overflow or underflow");

endmodule

// ----- design/lcg_back.sv -----
// Back end: takes jobs from the queue, applies the life rule and streams
// results through the output register. Depends on lcg_pkg.
module lcg_back (
  input  logic                      clk,
  input  logic                      rst,
  input  lcg_pkg::geom_t            geom,
  input  lcg_pkg::rule_t            rule,
  input  logic                      q_empty,
  input  lcg_pkg::job_t             q_head,
  output logic                      q_pop,
  input  logic                      pop,
  output logic                      out_valid,
  output logic                      next_alive,
  output logic [lcg_pkg::ROW_W-1:0] cell_row,
  output logic [lcg_pkg::COL_W-1:0] cell_col,
  output logic                      frame_done,
  output logic                      last_of_burst
);

  lcg_pkg::job_t               cur;
  logic                        cur_valid;
  logic                        pend_a;
  logic                        pend_b;
  logic [lcg_pkg::COL_W-1:0]   flush_idx;

  logic                        emit;
  logic                        em_last;
  logic                        em_done;
  lcg_pkg::win_t               em_win;
  logic [lcg_pkg::ROW_W-1:0]   em_row;
  logic [lcg_pkg::COL_W-1:0]   em_col;

  // Pick the next result of the current job
  always_comb begin
    em_done = 1'b0;
    if (pend_a) begin
      em_win  = cur.win_a;
      em_row  = cur.row - lcg_pkg::ROW_W'(1);
      em_col  = cur.col - lcg_pkg::COL_W'(1);
      em_last = !pend_b && !cur.flush;
    end else if (pend_b) begin
      em_win  = cur.win_b;
      em_row  = cur.row - lcg_pkg::ROW_W'(1);
      em_col  = cur.col;
      em_last = !cur.flush;
    end else begin
      em_win  = lcg_pkg::window3(cur.fl_up, cur.fl_mid, '0, flush_idx);
      em_row  = cur.row;
      em_col  = flush_idx;
      em_done = (flush_idx == geom.ncols_m1);
      em_last = em_done;
    end
    emit  = cur_valid && (!out_valid || pop);
    q_pop = !q_empty && (!cur_valid || (emit && em_last));
  end

  // Job sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      pend_a    <= 1'b0;
      pend_b    <= 1'b0;
      flush_idx <= '0;
    end else if (q_pop) begin
      cur_valid <= 1'b1;
      pend_a    <= q_head.emit_a;
      pend_b    <= q_head.emit_b;
      flush_idx <= '0;
    end else if (emit) begin
      if (em_last) begin
        cur_valid <= 1'b0;
      end
      if (pend_a) begin
        pend_a <= 1'b0;
      end else if (pend_b) begin
        pend_b <= 1'b0;
      end else begin
        flush_idx <= flush_idx + lcg_pkg::COL_W'(1);
      end
    end
  end

  // Job payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_head;
    end
  end

  // Output register: control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  // Output register: payload
  always_ff @(posedge clk) begin
    if (emit) begin
      next_alive    <= lcg_pkg::next_state(em_win, rule);
      cell_row      <= em_row;
      cell_col      <= em_col;
      frame_done    <= em_done;
      last_of_burst <= em_last;
    end
  end

  // Frame end always closes a burst
  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_done |-> last_of_burst)
    else $error("frame_done without last_of_burst");

  // Nothing is presented right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result present after reset");

  // A stalled result is held
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !pop |=> out_valid && $stable(cell_row) && $stable(cell_col))
    else $error("stalled result changed");

endmodule

// ----- design/life_cell_generation_stream.sv -----
// Top level of the life cell generation stream: configuration registers,
// front end, job queue and back end. Depends on lcg_pkg, lcg_front, lcg_queue, lcg_back.
//
// Usage: grid cells enter in raster order on cell_alive, a request taken when
// push is high and full is low. Results leave through empty/pop: the oldest
// result sits on next_alive, cell_row, cell_col, frame_done and last_of_burst
// while empty is low and is taken when pop is high. Cell (r-1,c-1) is reported
// when cell (r,c) arrives, cell (r-1,last) also at each row end, and the last
// cell of the frame flushes the whole last row (frame_done on its final cell).
// A request's job passes through the job queue and the current-job register
// before its first result reaches the output register. One cell is taken per
// cycle while full is low; the back end emits one result per cycle while the
// receiver pops; the 4-entry queue takes row-end and frame-end bursts before full rises.
// When the receiver stalls, the output register holds its result and the
// queue fills, then full stops input. Reset empties the queue, clears line
// buffers and positions and loads the default B3/S23 rule on a 1024x32 grid.
// Writing rows_in_use or cols_in_use restarts the frame.
module life_cell_generation_stream (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  logic                           cell_alive,
  output logic                           empty,
  input  logic                           pop,
  output logic                           next_alive,
  output logic [lcg_pkg::ROW_W-1:0]      cell_row,
  output logic [lcg_pkg::COL_W-1:0]      cell_col,
  output logic                           frame_done,
  output logic                           last_of_burst,
  input  logic                           cfg_we,
  input  logic [lcg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lcg_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic [lcg_pkg::ROWS_CFG_W-1:0] rows_in_use;
  logic [lcg_pkg::COLS_CFG_W-1:0] cols_in_use;
  lcg_pkg::rule_t                 rule;
  lcg_pkg::geom_t                 geom;
  logic                           restart;
  logic                           accept;
  logic                           job_push;
  lcg_pkg::job_t                  job;
  lcg_pkg::job_t                  q_head;
  logic                           q_empty;
  logic                           q_pop;
  logic                           out_valid;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= lcg_pkg::ROWS_RESET;
      cols_in_use <= lcg_pkg::COLS_RESET;
      rule.birth  <= lcg_pkg::BIRTH_RESET;
      rule.smin   <= lcg_pkg::SMIN_RESET;
      rule.smax   <= lcg_pkg::SMAX_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lcg_pkg::CFG_ROWS:  rows_in_use <= cfg_data;
        lcg_pkg::CFG_COLS:  cols_in_use <= cfg_data[lcg_pkg::COLS_CFG_W-1:0];
        lcg_pkg::CFG_BIRTH: rule.birth  <= cfg_data[lcg_pkg::RULE_W-1:0];
        lcg_pkg::CFG_SMIN:  rule.smin   <= cfg_data[lcg_pkg::RULE_W-1:0];
        lcg_pkg::CFG_SMAX:  rule.smax   <= cfg_data[lcg_pkg::RULE_W-1:0];
        default: ;
      endcase
    end
  end

  // Geometry writes restart the frame
  assign restart = cfg_we && ((cfg_index == lcg_pkg::CFG_ROWS) ||
                              (cfg_index == lcg_pkg::CFG_COLS));

  // Clamped geometry
  assign geom.ncols_m1 = lcg_pkg::last_col_idx(cols_in_use);
  assign geom.nrows_m1 = lcg_pkg::last_row_idx(rows_in_use);

  assign accept = push && !full;
  assign empty  = !out_valid;

  lcg_front u_front (
    .clk        (clk),
    .rst        (rst),
    .restart    (restart),
    .accept     (accept),
    .cell_alive (cell_alive),
    .geom       (geom),
    .job_push   (job_push),
    .job        (job)
  );

  lcg_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (job_push),
    .wr_data (job),
    .rd      (q_pop),
    .rd_data (q_head),
    .empty   (q_empty),
    .full    (full)
  );

  lcg_back u_back (
    .clk           (clk),
    .rst           (rst),
    .geom          (geom),
    .rule          (rule),
    .q_empty       (q_empty),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .pop           (pop),
    .out_valid     (out_valid),
    .next_alive    (next_alive),
    .cell_row      (cell_row),
    .cell_col      (cell_col),
    .frame_done    (frame_done),
    .last_of_burst (last_of_burst)
  );

endmodule

// ----- verif/life_cell_generation_stream_test.sv -----
// Self-checking testbench for life_cell_generation_stream: streams grid cells in raster order
// and checks every next-generation report against a behavioral predictor held here.
// Depends on lcg_pkg and the life_cell_generation_stream RTL only.
`timescale 1ns / 1ps

module life_cell_generation_stream_test;

  localparam int SETTLE_CYCLES = 10;    // quiet cycles before a register write
  localparam int DRAIN_CYCLES  = 40;    // quiet cycles at the end of the run
  localparam int LONG_HOLD     = 150;   // cycles the receiver holds off under pressure
  localparam int BUSY_PCT      = 73;
  localparam int BOTH_PCT      = 21;
  localparam int RANDOM_ITEMS  = 200;
  localparam int TIME_LIMIT    = 5_000_000;

  // Register indexes that decode to nothing
  localparam logic [lcg_pkg::CFG_IDX_W-1:0] SPARE_IDX_LO = 3'd5;
  localparam logic [lcg_pkg::CFG_IDX_W-1:0] SPARE_IDX_HI = 3'd7;

  typedef struct packed {
    logic                      next_alive;
    logic [lcg_pkg::ROW_W-1:0] cell_row;
    logic [lcg_pkg::COL_W-1:0] cell_col;
    logic                      frame_done;
    logic                      last_of_burst;
  } cell_report_t;

  // Reports of a 1x1 frame: cell (0,0), last of frame and of burst
  localparam cell_report_t NO_REPORT = '0;
  localparam cell_report_t LONE_DEAD = '{1'b0, 10'd0, 5'd0, 1'b1, 1'b1};
  localparam cell_report_t LONE_LIVE = '{1'b1, 10'd0, 5'd0, 1'b1, 1'b1};

  typedef enum bit {STIM_WRITE, STIM_CELL} stim_kind_t;
  typedef enum logic [1:0] {FLOW_FREE, FLOW_SOURCE, FLOW_SINK, FLOW_BOTH} flow_mode_t;

  typedef struct {
    stim_kind_t                    kind;
    logic [lcg_pkg::CFG_IDX_W-1:0] reg_idx;
    int                            value;
    bit                            alive;
    bit                            typed;
    cell_report_t                  want;
  } stim_row_t;

  logic                           clk;
  logic                           rst;
  logic                           push;
  logic                           full;
  logic                           cell_alive;
  logic                           empty;
  logic                           pop;
  logic                           next_alive;
  logic [lcg_pkg::ROW_W-1:0]      cell_row;
  logic [lcg_pkg::COL_W-1:0]      cell_col;
  logic                           frame_done;
  logic                           last_of_burst;
  logic                           cfg_we;
  logic [lcg_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [lcg_pkg::CFG_DATA_W-1:0] cfg_data;

  // Predictor state: configuration, line buffers and raster position
  logic [lcg_pkg::ROWS_CFG_W-1:0] grid_rows;
  logic [lcg_pkg::COLS_CFG_W-1:0] grid_cols;
  logic [lcg_pkg::RULE_W-1:0]     rule_birth;
  logic [lcg_pkg::RULE_W-1:0]     rule_smin;
  logic [lcg_pkg::RULE_W-1:0]     rule_smax;
  lcg_pkg::line_t                 line_up;
  lcg_pkg::line_t                 line_mid;
  lcg_pkg::line_t                 line_new;
  int                             at_row;
  int                             at_col;

  cell_report_t awaited_reports [$];
  cell_report_t burst [$];
  flow_mode_t   flow;
  int           hold_requests;
  int           mismatch_count;
  int           reports_checked;
  int           cells_sent;
  int           settings_used;

  // Directed part: rule and geometry corners, then small hand-made frames
  stim_row_t directed_rows [$] = '{
    '{STIM_WRITE, lcg_pkg::CFG_ROWS,  0,    1'b0, 1'b0, NO_REPORT},  // zero rows acts as one
    '{STIM_WRITE, lcg_pkg::CFG_COLS,  0,    1'b0, 1'b0, NO_REPORT},  // zero cols acts as one
    '{STIM_CELL,  lcg_pkg::CFG_ROWS,  0,    1'b1, 1'b1, LONE_DEAD},  // lonely cell dies
    '{STIM_CELL,  lcg_pkg::CFG_ROWS,  0,    1'b0, 1'b1, LONE_DEAD},
    '{STIM_WRITE, lcg_pkg::CFG_BIRTH, 0,    1'b0, 1'b0, NO_REPORT},
    '{STIM_CELL,  lcg_pkg::CFG_ROWS,  0,    1'b0, 1'b1, LONE_LIVE},  // born with no neighbors
    '{STIM_WRITE, lcg_pkg::CFG_SMIN,  0,    1'b0, 1'b0, NO_REPORT},
    '{STIM_WRITE, lcg_pkg::CFG_SMAX,  0,    1'b0, 1'b0, NO_REPORT},
    '{STIM_CELL,  lcg_pkg::CFG_ROWS,  0,    1'b1, 1'b1, LONE_LIVE},
    '{STIM_WRITE, lcg_pkg::CFG_SMIN,  9,    1'b0, 1'b0, NO_REPORT},  // min above max
    '{STIM_CELL,  lcg_pkg::CFG_ROWS,  0,    1'b1, 1'b1, LONE_DEAD},
    '{STIM_WRITE, lcg_pkg::CFG_BIRTH, 15,   1'b0, 1'b0, NO_REPORT},  // count never reached
    '{STIM_CELL,  lcg_pkg::CFG_ROWS,  0,    1'b0, 1'b1, LONE_DEAD},
    '{STIM_WRITE, SPARE_IDX_LO,       2047, 1'b0, 1'b0, NO_REPORT},  // unused indexes ignored
    '{STIM_WRITE, SPARE_IDX_HI,       2047, 1'b0, 1'b0, NO_REPORT},
    '{STIM_CELL,  lcg_pkg::CFG_ROWS,  0,    1'b0, 1'b1, LONE_DEAD},
    '{STIM_WRITE, lcg_pkg::CFG_BIRTH, 3,    1'b0, 1'b0, NO_REPORT},
    '{STIM_WRITE, lcg_pkg::CFG_SMIN,  2,    1'b0, 1'b0, NO_REPORT},
    '{STIM_WRITE, lcg_pkg::CFG_SMAX,  3,    1'b0, 1'b0, NO_REPORT},
    '{STIM_WRITE, lcg_pkg::CFG_ROWS,  3,    1'b0, 1'b0, NO_REPORT},
    '{STIM_WRITE, lcg_pkg::CFG_COLS,  3,    1'b0, 1'b0, NO_REPORT},
    '{STIM_CELL,  lcg_pkg::CFG_ROWS,  0,    1'b1, 1'b0, NO_REPORT},
    '{STIM_CELL,  lcg_pkg::CFG_ROWS,  0,    1'b1, 1'b0, NO_REPORT},
    '{STIM_CELL,  lcg_pkg::CFG_ROWS,  0,    1'b1, 1'b0, NO_REPORT},
    '{STIM_CELL,  lcg_pkg::CFG_ROWS,  0,    1'b0, 1'b0, NO_REPORT},
    '{STIM_WRITE, lcg_pkg::CFG_COLS,  3,    1'b0, 1'b0, NO_REPORT},  // restart mid-frame
    '{STIM_CELL,  lcg_pkg::CFG_ROWS,  0,    1'b0, 1'b0, NO_REPORT},  // blinker, 3x3
    '{STIM_CELL,  lcg_pkg::CFG_ROWS,  0,    1'b1, 1'b0, NO_REPORT},
    '{STIM_CELL,  lcg_pkg::CFG_ROWS,  0,    1'b0, 1'b0, NO_REPORT},
    '{STIM_CELL,  lcg_pkg::CFG_ROWS,  0,    1'b0, 1'b0, NO_REPORT},
    '{STIM_CELL,  lcg_pkg::CFG_ROWS,  0,    1'b1, 1'b0, NO_REPORT},
    '{STIM_CELL,  lcg_pkg::CFG_ROWS,  0,    1'b0, 1'b0, NO_REPORT},
    '{STIM_CELL,  lcg_pkg::CFG_ROWS,  0,    1'b0, 1'b0, NO_REPORT},
    '{STIM_CELL,  lcg_pkg::CFG_ROWS,  0,    1'b1, 1'b0, NO_REPORT},
    '{STIM_CELL,  lcg_pkg::CFG_ROWS,  0,    1'b0, 1'b0, NO_REPORT},
    '{STIM_WRITE, lcg_pkg::CFG_ROWS,  2,    1'b0, 1'b0, NO_REPORT},  // 2x2 block
    '{STIM_WRITE, lcg_pkg::CFG_COLS,  2,    1'b0, 1'b0, NO_REPORT},
    '{STIM_CELL,  lcg_pkg::CFG_ROWS,  0,    1'b1, 1'b0, NO_REPORT},
    '{STIM_CELL,  lcg_pkg::CFG_ROWS,  0,    1'b1, 1'b0, NO_REPORT},
    '{STIM_CELL,  lcg_pkg::CFG_ROWS,  0,    1'b1, 1'b0, NO_REPORT},
    '{STIM_CELL,  lcg_pkg::CFG_ROWS,  0,    1'b1, 1'b0, NO_REPORT}
  };

  life_cell_generation_stream uut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .cell_alive   (cell_alive),
    .empty        (empty),
    .pop          (pop),
    .next_alive   (next_alive),
    .cell_row     (cell_row),
    .cell_col     (cell_col),
    .frame_done   (frame_done),
    .last_of_burst(last_of_burst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(TIME_LIMIT);
    $display("%0t: timeout, %0d reports still awaited", $time, awaited_reports.size());
    $display("CHECKS FAILED");
    $finish;
  end

  // Percentage of cycles a busy side stays idle in the current mode
  function automatic int gap_pct();
    return (flow == FLOW_BOTH) ? BOTH_PCT : BUSY_PCT;
  endfunction

  function automatic void clear_frame();
    line_up  = '0;
    line_mid = '0;
    line_new = '0;
    at_row   = 0;
    at_col   = 0;
  endfunction

  // Next state of column col of the middle line; cells off the grid are dead
  function automatic bit evolve(lcg_pkg::line_t up, lcg_pkg::line_t mid, lcg_pkg::line_t dn,
                                int col, int ncols);
    int n;
    int lo;
    int hi;
    n  = 0;
    lo = (col > 0) ? col - 1 : col;
    hi = (col + 1 < ncols) ? col + 1 : col;
    for (int j = lo; j <= hi; j++) n += up[j] + mid[j] + dn[j];
    n -= mid[col];
    if (!mid[col]) return n == int'(rule_birth);
    return (n >= int'(rule_smin)) && (n <= int'(rule_smax));
  endfunction

  function automatic void add_report(bit alive, int r, int c, bit done);
    burst.push_back('{alive, lcg_pkg::ROW_W'(r), lcg_pkg::COL_W'(c), done, 1'b0});
  endfunction

  // Advance the raster position by one cell and collect the reports it releases
  function automatic void predict_cell(bit alive, bit keep);
    int ncols;
    int nrows;
    int r;
    int c;
    burst.delete();
    ncols = (grid_cols == 0) ? 1 :
            (grid_cols > lcg_pkg::MAX_COLS) ? lcg_pkg::MAX_COLS : int'(grid_cols);
    nrows = (grid_rows == 0) ? 1 :
            (grid_rows > lcg_pkg::MAX_ROWS) ? lcg_pkg::MAX_ROWS : int'(grid_rows);
    r = at_row;
    c = at_col;
    if (c >= ncols || r >= nrows) begin
      clear_frame();
      r = 0;
      c = 0;
    end
    if (alive) line_new[c] = 1'b1;

    // row above is complete up to this column
    if (r >= 1) begin
      if (c >= 1)
        add_report(evolve(line_up, line_mid, line_new, c - 1, ncols), r - 1, c - 1, 1'b0);
      if (c == ncols - 1)
        add_report(evolve(line_up, line_mid, line_new, c, ncols), r - 1, c, 1'b0);
    end

    if (c == ncols - 1) begin
      if (r == nrows - 1) begin
        // frame end: flush the last row against a dead row below
        for (int j = 0; j < ncols; j++)
          add_report(evolve(line_mid, line_new, '0, j, ncols), r, j, j == ncols - 1);
        clear_frame();
      end else begin
        line_up  = line_mid;
        line_mid = line_new;
        line_new = '0;
        at_col   = 0;
        at_row   = r + 1;
      end
    end else begin
      at_col = c + 1;
      at_row = r;
    end

    if (burst.size() > 0) burst[burst.size() - 1].last_of_burst = 1'b1;
    if (keep) foreach (burst[i]) awaited_reports.push_back(burst[i]);
  endfunction

  // Offer one cell, with random gaps ahead of it when the sender idles
  task automatic send_cell(input bit alive, input bit typed, input cell_report_t want);
    if (flow == FLOW_SOURCE || flow == FLOW_BOTH) begin
      while ($urandom_range(99) < gap_pct()) begin
        @(negedge clk);
        push       <= 1'b0;
        cell_alive <= 1'($urandom);
      end
    end
    @(negedge clk);
    push       <= 1'b1;
    cell_alive <= alive;
    do @(posedge clk); while (full);
    predict_cell(alive, !typed);
    if (typed) awaited_reports.push_back(want);
    cells_sent++;
  endtask

  // Register write once the block has gone quiet
  task automatic write_register(input logic [lcg_pkg::CFG_IDX_W-1:0] idx, input int data);
    logic [lcg_pkg::CFG_DATA_W-1:0] word;
    word = lcg_pkg::CFG_DATA_W'(data);
    @(negedge clk);
    push <= 1'b0;
    while (awaited_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= word;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      lcg_pkg::CFG_ROWS: begin
        grid_rows = word[lcg_pkg::ROWS_CFG_W-1:0];
        clear_frame();
      end
      lcg_pkg::CFG_COLS: begin
        grid_cols = word[lcg_pkg::COLS_CFG_W-1:0];
        clear_frame();
      end
      lcg_pkg::CFG_BIRTH: rule_birth = word[lcg_pkg::RULE_W-1:0];
      lcg_pkg::CFG_SMIN:  rule_smin  = word[lcg_pkg::RULE_W-1:0];
      lcg_pkg::CFG_SMAX:  rule_smax  = word[lcg_pkg::RULE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic check_field(input string field, input logic [15:0] want_v,
                             input logic [15:0] got_v, input cell_report_t want);
    if (got_v !== want_v) begin
      mismatch_count++;
      $display("%0t: %s of cell (%0d,%0d) expected %0d got %0d", $time, field,
               want.cell_row, want.cell_col, want_v, got_v);
    end
  endtask

  // Receiver: pops every cycle or at random, by flow mode, or holds off for a long stretch on request
  initial begin : result_drain
    int hold_left;
    int holds_seen;
    hold_left  = 0;
    holds_seen = 0;
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_requests != holds_seen) begin
        holds_seen = hold_requests;
        hold_left  = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (flow == FLOW_SINK || flow == FLOW_BOTH) begin
        pop <= ($urandom_range(99) >= gap_pct());
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Compare each popped report with the oldest awaited one
  always @(posedge clk) begin : report_check
    cell_report_t got;
    cell_report_t want;
    if (!rst && pop && !empty) begin
      got = '{next_alive, cell_row, cell_col, frame_done, last_of_burst};
      if (awaited_reports.size() == 0) begin
        mismatch_count++;
        $display("%0t: report for cell (%0d,%0d) expected none got next_alive %0d",
                 $time, cell_row, cell_col, next_alive);
      end else begin
        want = awaited_reports.pop_front();
        reports_checked++;
        check_field("next_alive", 16'(want.next_alive), 16'(got.next_alive), want);
        check_field("cell_row", 16'(want.cell_row), 16'(got.cell_row), want);
        check_field("cell_col", 16'(want.cell_col), 16'(got.cell_col), want);
        check_field("frame_done", 16'(want.frame_done), 16'(got.frame_done), want);
        check_field("last_of_burst", 16'(want.last_of_burst), 16'(got.last_of_burst), want);
      end
    end
  end

  // Main sequence: reset, directed table, random phases, drain
  initial begin : stimulus
    int rows;
    int cols;
    int frames;
    int partial;
    int density;
    int random_cells;
    rst        = 1'b1;
    push       = 1'b0;
    cell_alive = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = lcg_pkg::CFG_ROWS;
    cfg_data   = '0;
    flow       = FLOW_FREE;
    hold_requests   = 0;
    mismatch_count  = 0;
    reports_checked = 0;
    cells_sent      = 0;
    settings_used   = 1;
    random_cells    = 0;
    grid_rows  = lcg_pkg::ROWS_RESET;
    grid_cols  = lcg_pkg::COLS_RESET;
    rule_birth = lcg_pkg::BIRTH_RESET;
    rule_smin  = lcg_pkg::SMIN_RESET;
    rule_smax  = lcg_pkg::SMAX_RESET;
    clear_frame();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == STIM_WRITE) begin
        write_register(directed_rows[i].reg_idx, directed_rows[i].value);
        settings_used++;
      end else begin
        send_cell(directed_rows[i].alive, directed_rows[i].typed, directed_rows[i].want);
      end
    end

    // Random phases: mostly whole frames, some cut short by a geometry write
    for (int ph = 0; random_cells < RANDOM_ITEMS; ph++) begin
      flow    = flow_mode_t'(ph % 4);
      rows    = $urandom_range(1, 4);
      cols    = $urandom_range(1, 8);
      frames  = $urandom_range(1, 3);
      partial = 0;
      case (ph)
        1: begin          // cols above the limit, widest flush plus row end
          rows = 2; cols = 63; frames = 1;
        end
        3: begin          // rows above the limit, frame left unfinished
          rows = 2047; cols = 1; frames = 0; partial = 20;
        end
        4: begin          // long receiver hold while cells keep coming
          rows = 6; cols = 8; frames = 2;
        end
        6: begin          // single full-width row
          rows = 1; cols = 32; frames = 1;
        end
        default:
          if (rows * cols > 1 && $urandom_range(3) == 0)
            partial = $urandom_range(1, rows * cols - 1);
      endcase
      write_register(lcg_pkg::CFG_BIRTH, ($urandom_range(9) < 7) ? 3 : $urandom_range(15));
      write_register(lcg_pkg::CFG_SMIN, ($urandom_range(9) < 7) ? 2 : $urandom_range(15));
      write_register(lcg_pkg::CFG_SMAX, ($urandom_range(9) < 7) ? 3 : $urandom_range(15));
      write_register(lcg_pkg::CFG_ROWS, rows);
      write_register(lcg_pkg::CFG_COLS, cols);
      settings_used++;
      if (ph == 4) begin
        @(posedge clk);
        hold_requests++;
      end
      density = $urandom_range(20, 70);
      for (int i = 0; i < frames * rows * cols + partial; i++) begin
        send_cell($urandom_range(99) < density, 1'b0, NO_REPORT);
        random_cells++;
      end
    end

    // Drain and wrap up
    flow = FLOW_FREE;
    @(negedge clk);
    push <= 1'b0;
    while (awaited_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Streamed %0d cells under %0d register settings; %0d next-state reports checked,",
             cells_sent, settings_used, reports_checked);
    $display("including out-of-range geometry, mid-frame restarts and a long output stall.");
    if (mismatch_count == 0 && awaited_reports.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/lcg_pkg.sv
design/lcg_front.sv
design/lcg_queue.sv
design/lcg_back.sv
design/life_cell_generation_stream.sv
verif/life_cell_generation_stream_test.sv
